@@ src/crc16bg_pkg.sv @@
// ----------------------------------------------------------------------------
// crc16bg_pkg
// Shared types and constants for the bit-granular CRC-16 update block.
// ----------------------------------------------------------------------------
package crc16bg_pkg;

   localparam int DATA_W  = 8;
   localparam int START_W = 3;
   localparam int COUNT_W = 4;
   localparam int CRC_W   = 16;

   localparam logic [CRC_W-1:0] CRC_POLY  = 16'h8005;
   localparam logic [CRC_W-1:0] CRC_RESET = 16'hFFFF;

   // register map: one register slot per 4 bytes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_INITIAL_CRC = 1'b0;

   typedef struct packed {
      logic [DATA_W-1:0]  data_byte;
      logic [START_W-1:0] first_bit;
      logic [COUNT_W-1:0] bit_count;
      logic               restart;
   } item_type;

endpackage

@@ src/crc16bg_core.sv @@
// ----------------------------------------------------------------------------
// crc16bg_core
// Combinational CRC update: clamp the count, then feed up to eight bits.
// ----------------------------------------------------------------------------
module crc16bg_core (
   input  crc16bg_pkg::item_type              item,
   input  logic [crc16bg_pkg::CRC_W-1:0]      crc_now,
   input  logic [crc16bg_pkg::CRC_W-1:0]      initial_crc,
   output logic [crc16bg_pkg::CRC_W-1:0]      crc_next
);
   import crc16bg_pkg::*;

   logic [COUNT_W-1:0] room;
   logic [COUNT_W-1:0] count;
   logic [DATA_W-1:0]  aligned;

   assign room    = COUNT_W'(DATA_W) - {1'b0, item.first_bit};
   assign count   = (item.bit_count > room) ? room : item.bit_count;
   // shift the first used bit up to the MSB
   assign aligned = item.data_byte << item.first_bit;

   always_comb begin
      logic [CRC_W-1:0] crc;
      logic             fb;
      crc = item.restart ? initial_crc : crc_now;
      for (int i = 0; i < DATA_W; i++) begin
         fb = crc[CRC_W-1] ^ aligned[DATA_W-1-i];
         if (COUNT_W'(i) < count) begin
            crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
         end
      end
      crc_next = crc;
   end

endmodule

@@ src/crc16bg_csr.sv @@
// ----------------------------------------------------------------------------
// crc16bg_csr
// APB register file holding the initial CRC value.
// ----------------------------------------------------------------------------
module crc16bg_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [crc16bg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crc16bg_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [crc16bg_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                 pready,
   output logic [crc16bg_pkg::CRC_W-1:0]        initial_crc
);
   import crc16bg_pkg::*;

   logic [CRC_W-1:0] initial_crc_ff;
   logic [CRC_W-1:0] initial_crc_in;
   logic             hit;

   assign pready = 1'b1;
   assign hit    = (paddr[CSR_ADDR_W-1] == REG_INITIAL_CRC);

   always_comb begin
      initial_crc_in = initial_crc_ff;
      if (psel && penable && pwrite && pready && hit) begin
         initial_crc_in = pwdata[CRC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_crc_ff <= CRC_RESET;
      end else begin
         initial_crc_ff <= initial_crc_in;
      end
   end

   assign prdata      = hit ? {(CSR_DATA_W-CRC_W)'(0), initial_crc_ff} : '0;
   assign initial_crc = initial_crc_ff;

endmodule

@@ src/crc16_bit_granular_update.sv @@
// ----------------------------------------------------------------------------
// crc16_bit_granular_update
// Running CRC-16 (poly 0x8005, MSB first) fed a bit range of one byte per
// request.
// ----------------------------------------------------------------------------
// Each request carries a data byte, the first bit to use (counted from the
// MSB), a bit count and a restart flag. The count is clamped to the bits left
// in the byte; restart loads the configured initial CRC first. Every request
// yields one response: the CRC register after its bits. Throughput is one
// request per cycle while the response side keeps up; a request passes the
// input register, then the eight-step update into the result register, which
// also writes the running CRC so the next request sees it, and its response
// is valid from there. A response left waiting holds the request in the
// input register, and a further request stalls until the response drains.
// The initial CRC lives at byte address 0 of the APB port (reset 0xFFFF) and
// is to be written only while no request is in flight.
// ----------------------------------------------------------------------------
module crc16_bit_granular_update (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [crc16bg_pkg::DATA_W-1:0]       req_data_byte,
   input  logic [crc16bg_pkg::START_W-1:0]      req_first_bit,
   input  logic [crc16bg_pkg::COUNT_W-1:0]      req_bit_count,
   input  logic                                 req_restart,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [crc16bg_pkg::CRC_W-1:0]        rsp_crc_out,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [crc16bg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crc16bg_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [crc16bg_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                 pready
);
   import crc16bg_pkg::*;

   logic [CRC_W-1:0] initial_crc;

   // input stage
   item_type         item_ff;
   item_type         item_in;
   logic             item_valid_ff;
   logic             item_valid_in;

   // running CRC and result register
   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] crc_next;
   logic [CRC_W-1:0] rsp_crc_ff;
   logic [CRC_W-1:0] rsp_crc_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   logic             advance;
   logic             req_take;

   crc16bg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .initial_crc (initial_crc)
   );

   crc16bg_core u_core (
      .item        (item_ff),
      .crc_now     (crc_ff),
      .initial_crc (initial_crc),
      .crc_next    (crc_next)
   );

   // Advance the input stage into the result register whenever the result
   // slot is empty or being drained this cycle.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      crc_in        = crc_ff;
      rsp_crc_in    = rsp_crc_ff;
      rsp_valid_in  = rsp_valid_ff;

      // drop a delivered response
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // retire the held request: commit the CRC and present the response
      if (advance) begin
         crc_in        = crc_next;
         rsp_crc_in    = crc_next;
         rsp_valid_in  = 1'b1;
         item_valid_in = 1'b0;
      end
      // capture a new request
      if (req_take) begin
         item_in.data_byte = req_data_byte;
         item_in.first_bit = req_first_bit;
         item_in.bit_count = req_bit_count;
         item_in.restart   = req_restart;
         item_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         crc_ff        <= CRC_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         crc_ff        <= crc_in;
      end
      item_ff    <= item_in;
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_crc_out = rsp_crc_ff;

   // the running CRC always matches the last response produced
   a_crc_tracks_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> (crc_ff == rsp_crc_ff) && rsp_valid_ff)
      else $error("running CRC and response disagree");

   // back-pressure only while a request is held
   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> item_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled with a free stage");

   // an accepted request always occupies the input stage next cycle
   a_take_fills_stage : assert property (@(posedge clock) disable iff (reset)
      req_take |=> item_valid_ff)
      else $error("accepted request lost");

   // reset restores the CRC and empties the pipeline
   a_reset_state : assert property (@(posedge clock)
      reset |=> (crc_ff == CRC_RESET) && !rsp_valid_ff && !item_valid_ff)
      else $error("bad state after reset");

endmodule

@@ test/crc16_update_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_update_checker
// Watches the request, response and APB ports of the bit-granular CRC-16
// block and predicts and compares every response and each read at byte address 0.
// ----------------------------------------------------------------------------
module crc16_update_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [crc16bg_pkg::DATA_W-1:0]       req_data_byte,
   input  logic [crc16bg_pkg::START_W-1:0]      req_first_bit,
   input  logic [crc16bg_pkg::COUNT_W-1:0]      req_bit_count,
   input  logic                                 req_restart,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [crc16bg_pkg::CRC_W-1:0]        rsp_crc_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [crc16bg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crc16bg_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [crc16bg_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                                 pready,
   output int                                   fail_count,
   output int                                   outstanding
);
   import crc16bg_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] INIT_CRC_ADDR = CSR_ADDR_W'(4 * int'(REG_INITIAL_CRC));

   logic [CRC_W-1:0] crc_expected[$];
   logic [CRC_W-1:0] running_crc;
   logic [CRC_W-1:0] initial_crc;
   int               mismatch_count = 0;

   assign fail_count = mismatch_count;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Shift the selected bits of one request into the register, MSB first.
   function automatic logic [CRC_W-1:0] crc_after_request(input logic [CRC_W-1:0] running,
                                                          input logic [CRC_W-1:0] seed,
                                                          input item_type req);
      logic [CRC_W-1:0] crc;
      int               first;
      int               taken;
      logic             feedback;
      crc   = req.restart ? seed : running;
      first = int'(req.first_bit);
      taken = int'(req.bit_count);
      if (taken > DATA_W - first)
         taken = DATA_W - first;
      for (int i = 0; i < taken; i++) begin
         feedback = crc[CRC_W-1] ^ req.data_byte[DATA_W-1-first-i];
         crc      = {crc[CRC_W-2:0], 1'b0} ^ (feedback ? CRC_POLY : '0);
      end
      return crc;
   endfunction

   always @(posedge clock) begin
      item_type         req;
      logic [CRC_W-1:0] want;
      if (reset) begin
         crc_expected.delete();
         running_crc = CRC_RESET;
         initial_crc = CRC_RESET;
      end else begin
         if (psel && penable && pready && paddr == INIT_CRC_ADDR) begin
            if (pwrite)
               initial_crc = pwdata[CRC_W-1:0];
            else if (prdata[CRC_W-1:0] !== initial_crc)
               report_mismatch($sformatf("initial_crc read %h, expected %h",
                                         prdata[CRC_W-1:0], initial_crc));
         end
         if (rsp_valid && rsp_ready) begin
            if (crc_expected.size() == 0) begin
               report_mismatch($sformatf("response crc_out %h with no request pending",
                                         rsp_crc_out));
            end else begin
               want = crc_expected.pop_front();
               if (rsp_crc_out !== want)
                  report_mismatch($sformatf("crc_out %h, expected %h", rsp_crc_out, want));
            end
         end
         if (req_valid && req_ready) begin
            req.data_byte = req_data_byte;
            req.first_bit = req_first_bit;
            req.bit_count = req_bit_count;
            req.restart   = req_restart;
            running_crc   = crc_after_request(running_crc, initial_crc, req);
            crc_expected.push_back(running_crc);
         end
      end
      outstanding <= crc_expected.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the bit-granular CRC-16 bench: drives requests, responses and the
// APB port with random idling, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
// A directed set covers the byte extremes, single bits at both ends, counts
// that run past the end of the byte, zero counts with and without restart,
// and a frame header. Random frames follow under three idling profiles, with
// the initial CRC rewritten between them to zero, all ones and other values.
// ----------------------------------------------------------------------------
module tb;
   import crc16bg_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEMS_PER_PHASE = 300;
   localparam logic [CSR_ADDR_W-1:0] INIT_CRC_ADDR = CSR_ADDR_W'(4 * int'(REG_INITIAL_CRC));

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_data_byte;
   logic [START_W-1:0]    req_first_bit;
   logic [COUNT_W-1:0]    req_bit_count;
   logic                  req_restart;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CRC_W-1:0]      rsp_crc_out;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int outstanding;
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;
   int sent_count;

   crc16_bit_granular_update uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_first_bit (req_first_bit),
      .req_bit_count (req_bit_count),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_crc_out   (rsp_crc_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   crc16_update_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_first_bit (req_first_bit),
      .req_bit_count (req_bit_count),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_crc_out   (rsp_crc_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Watchdog: end the run if the bench stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[crc16_bit_granular_update] ERROR");
         $finish;
      end
   end

   // Response side: drop ready at random, per the current idling profile.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Present one request at a falling edge, after random idle cycles, and
   // hold it until the block takes it at a rising edge.
   task automatic send_request(input logic [DATA_W-1:0] data, input logic [START_W-1:0] first,
                               input logic [COUNT_W-1:0] count, input logic restart);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_first_bit <= first;
      req_bit_count <= count;
      req_restart   <= restart;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent_count++;
   endtask

   // Stop sending and wait until every predicted response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      // cover the block's two-stage pipeline
      repeat (4) @(posedge clock);
   endtask

   // APB transfer: setup cycle, then access cycle until pready.
   task automatic apb_transfer(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write the seed, then read it back; the checker compares the read data.
   task automatic set_initial_crc(input logic [CRC_W-1:0] seed);
      drain_responses();
      apb_transfer(1'b1, INIT_CRC_ADDR, CSR_DATA_W'(seed));
      apb_transfer(1'b0, INIT_CRC_ADDR, '0);
   endtask

   // Random frames: mostly a restart followed by whole bytes, with some
   // bit-granular pieces mixed in, plus a share of fully random noise.
   task automatic send_random_frames(input int item_target);
      int               goal;
      int               frame_len;
      int               next_drain;
      logic [START_W-1:0] first;
      logic [COUNT_W-1:0] count;
      logic             restart;
      goal       = sent_count + item_target;
      next_drain = sent_count + $urandom_range(80, 160);
      while (sent_count < goal) begin
         frame_len = $urandom_range(1, 12);
         for (int k = 0; k < frame_len; k++) begin
            if ($urandom_range(9) == 0) begin
               first   = START_W'($urandom_range(7));
               count   = COUNT_W'($urandom_range(15));
               restart = $urandom_range(1);
            end else begin
               restart = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
               if ($urandom_range(9) < 7) begin
                  first = '0;
                  count = COUNT_W'(DATA_W);
               end else begin
                  first = START_W'($urandom_range(7));
                  count = COUNT_W'($urandom_range(15));
               end
            end
            send_request(DATA_W'($urandom_range(255)), first, count, restart);
         end
         // hold off now and then until the pipeline is empty
         if (sent_count >= next_drain) begin
            drain_responses();
            next_drain = sent_count + $urandom_range(80, 160);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_first_bit = '0;
      req_bit_count = '0;
      req_restart   = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      cycle_count   = 0;
      sent_count    = 0;
      send_idle_pct = 38;
      recv_idle_pct = 69;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Read the seed out of reset, then run the directed set with it.
      apb_transfer(1'b0, INIT_CRC_ADDR, '0);
      send_request(8'hFF, 3'd0, 4'd8,  1'b1);
      send_request(8'h00, 3'd0, 4'd8,  1'b0);
      send_request(8'h80, 3'd0, 4'd1,  1'b0);  // MSB alone
      send_request(8'h01, 3'd7, 4'd1,  1'b0);  // LSB alone
      send_request(8'hA5, 3'd3, 4'd5,  1'b0);  // ends exactly at the LSB
      send_request(8'h5A, 3'd3, 4'd9,  1'b0);  // runs past the byte
      send_request(8'hC3, 3'd7, 4'd15, 1'b0);  // largest count, last bit
      send_request(8'h3C, 3'd0, 4'd15, 1'b0);  // largest count, whole byte
      send_request(8'h77, 3'd4, 4'd0,  1'b0);  // nothing fed
      send_request(8'hE1, 3'd2, 4'd0,  1'b1);  // nothing fed, seed loaded
      send_request(8'h12, 3'd5, 4'd2,  1'b1);
      send_request(8'hFF, 3'd7, 4'd8,  1'b0);
      send_request(8'h00, 3'd1, 4'd7,  1'b1);
      send_request(8'hAA, 3'd2, 4'd4,  1'b0);
      send_request(8'h55, 3'd6, 4'd2,  1'b0);
      // frame header, byte by byte
      send_request(8'hFF, 3'd0, 4'd8,  1'b1);
      send_request(8'hFB, 3'd0, 4'd8,  1'b0);
      send_request(8'h90, 3'd0, 4'd8,  1'b0);
      send_request(8'h64, 3'd0, 4'd8,  1'b0);

      // Zero seed, then the first random phase.
      set_initial_crc(16'h0000);
      send_request(8'h00, 3'd0, 4'd8,  1'b1);
      send_request(8'h80, 3'd0, 4'd12, 1'b0);
      send_random_frames(ITEMS_PER_PHASE);

      // All-ones seed, idling swapped between the two sides.
      set_initial_crc(16'hFFFF);
      send_idle_pct = 69;
      recv_idle_pct = 38;
      send_random_frames(ITEMS_PER_PHASE);

      // Back to back: a random seed, then the polynomial itself.
      set_initial_crc(CRC_W'($urandom_range(16'hFFFF)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_frames(ITEMS_PER_PHASE / 2);
      set_initial_crc(CRC_POLY);
      send_random_frames(ITEMS_PER_PHASE / 2);

      // Let the last responses drain, then give the verdict.
      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[crc16_bit_granular_update] OK");
      else
         $display("[crc16_bit_granular_update] ERROR");
      $finish;
   end

endmodule
